// ----- design/pgs_pkg.sv -----
`default_nettype none

package pgs_pkg;

  // Grid bound and fixed field widths
  localparam int MAX_GRID = 16;
  localparam int DATA_W   = 32;
  localparam int GRID_W   = 5;
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 12;
  localparam int DIAG_W   = 4;
  localparam int RESET_GRID = 16;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SWEEP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  // Base diagonal of the 7-point stencil
  localparam logic [DIAG_W-1:0] DIAG_BASE = 4'd6;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [INDEX_W-1:0]        cell_index;
    logic signed [DATA_W-1:0]  source_value;
  } pgs_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  solution_value;
    logic                      status;
  } pgs_rsp_t;

  // Saturating signed add
  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? VAL_MIN : VAL_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/pgs_div.sv -----
`default_nettype none

// Signed dividend over small unsigned divisor, one quotient bit per cycle,
// truncating toward zero.
module pgs_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [pgs_pkg::DATA_W-1:0]    dividend_i,
  input  wire logic [pgs_pkg::DIAG_W-1:0]           divisor_i,
  output logic                                      done_o,
  output logic signed [pgs_pkg::DATA_W-1:0]         quotient_o
);

  localparam int W     = pgs_pkg::DATA_W;
  localparam int CNT_W = $clog2(W + 1);
  localparam int REM_W = pgs_pkg::DIAG_W + 1;

  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic                         neg_q, neg_d;
  logic [W-1:0]                 mag_q, mag_d;
  logic [REM_W-1:0]             rem_q, rem_d;
  logic [pgs_pkg::DIAG_W-1:0]   den_q, den_d;
  logic [REM_W-1:0]             trial;

  // One restoring step per cycle
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[REM_W-2:0], mag_q[W-1]};
    if (start_i) begin
      neg_d = dividend_i[W-1];
      mag_d = dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
      rem_d = '0;
      den_d = divisor_i;
      cnt_d = CNT_W'(W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        mag_d = {mag_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        mag_d = {mag_q[W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // Restore the sign
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

`default_nettype wire

// ----- design/pgs_store.sv -----
`default_nettype none

// Source and solution memories, one write and one registered read each
module pgs_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                src_we_i,
  input  wire logic                                sol_we_i,
  input  wire logic [ADDR_W-1:0]                   wr_addr_i,
  input  wire logic signed [pgs_pkg::DATA_W-1:0]   src_wdata_i,
  input  wire logic signed [pgs_pkg::DATA_W-1:0]   sol_wdata_i,
  input  wire logic [ADDR_W-1:0]                   src_raddr_i,
  input  wire logic [ADDR_W-1:0]                   sol_raddr_i,
  output logic signed [pgs_pkg::DATA_W-1:0]        src_rdata_o,
  output logic signed [pgs_pkg::DATA_W-1:0]        sol_rdata_o
);

  logic signed [pgs_pkg::DATA_W-1:0] src_mem [DEPTH];
  logic signed [pgs_pkg::DATA_W-1:0] sol_mem [DEPTH];

  // Source memory
  always_ff @(posedge clk_i) begin
    if (src_we_i) begin
      src_mem[wr_addr_i] <= src_wdata_i;
    end
    src_rdata_o <= src_mem[src_raddr_i];
  end

  // Solution memory
  always_ff @(posedge clk_i) begin
    if (sol_we_i) begin
      sol_mem[wr_addr_i] <= sol_wdata_i;
    end
    sol_rdata_o <= sol_mem[sol_raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/poisson_gauss_seidel_sweep_top.sv -----
// Channel      Signals                        Transfer
// command      start, busy, req_i             taken when start is high and busy is low
// result       done_o, rsp_o                  one cycle, marked by done_o
// grid size    cfg_we_i, cfg_wdata_i          written when cfg_we_i is high
//
// Load, read and unused codes leave busy low, so one such transaction can be
// taken every cycle and its result shows the next cycle.
// For each cell a sweep gathers the neighbor reads through one saturating adder,
// then divides the sum by the diagonal in the divider and writes the quotient back.
// busy is high for the whole sweep. Reset is asynchronous, active low.
// The memories are not cleared, and the receiver cannot stall the result.
`default_nettype none

module poisson_gauss_seidel_sweep_top #(
  parameter int MAX_GRID = pgs_pkg::MAX_GRID
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire pgs_pkg::pgs_req_t                  req_i,
  output logic                                    done_o,
  output pgs_pkg::pgs_rsp_t                       rsp_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [pgs_pkg::GRID_W-1:0]         cfg_wdata_i
);

  localparam int W      = pgs_pkg::DATA_W;
  localparam int N_W    = $clog2(MAX_GRID + 1);
  localparam int PL_W   = $clog2(MAX_GRID * MAX_GRID + 1);
  localparam int DEPTH  = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RST_N  = (pgs_pkg::RESET_GRID > MAX_GRID) ? MAX_GRID : pgs_pkg::RESET_GRID;
  localparam int RST_PL = RST_N * RST_N;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GATHER = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;

  localparam logic [2:0] PH_LAST_READ = 3'd5;
  localparam logic [2:0] PH_LAST_ADD  = 3'd6;
  localparam logic [2:0] PH_DIV_GO    = 3'd7;

  // Control state
  logic [1:0]         state_q, state_d;
  logic [2:0]         ph_q, ph_d;
  logic               done_q, done_d;
  logic [N_W-1:0]     n_q, n_d;
  logic [PL_W-1:0]    plane_q, plane_d;

  // Working state
  logic [ADDR_W-1:0]  c_q, c_d;
  logic [N_W-1:0]     j_q, j_d, i_q, i_d, k_q, k_d;
  logic signed [W-1:0] acc_q, acc_d;
  logic               nb_ok_q, nb_ok_d;
  logic               rd_q, rd_d;
  logic               stat_q, stat_d;

  logic [2*N_W-1:0]     n_sq;
  logic [PL_W+N_W-1:0]  n_cube;
  logic [CNT_W-1:0]     cells;
  logic [N_W-1:0]       n_last;
  logic                 accept;
  logic                 in_grid;
  logic                 last_cell;

  logic                 nb_ok;
  logic [ADDR_W-1:0]    nb_addr;
  logic [ADDR_W-1:0]    plane_a, n_a;
  logic signed [W-1:0]  add_a, add_b;
  logic [pgs_pkg::DIAG_W-1:0] diag;

  logic                 src_we, sol_we;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic signed [W-1:0]  sol_wdata;
  logic signed [W-1:0]  src_rdata, sol_rdata;

  logic                 div_start, div_done;
  logic signed [W-1:0]  div_quo;

  // Clamp grid size on write and keep its square
  always_comb begin
    if (cfg_wdata_i == '0) begin
      n_d = N_W'(1);
    end else if (int'(cfg_wdata_i) > MAX_GRID) begin
      n_d = N_W'(MAX_GRID);
    end else begin
      n_d = N_W'(cfg_wdata_i);
    end
    n_sq    = n_d * n_d;
    plane_d = PL_W'(n_sq);
  end

  assign n_cube = plane_q * n_q;
  assign cells  = CNT_W'(n_cube);
  assign n_last = n_q - N_W'(1);

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign in_grid = (32'(req_i.cell_index) < 32'(cells));

  assign plane_a   = ADDR_W'(plane_q);
  assign n_a       = ADDR_W'(n_q);
  assign last_cell = (j_q == n_last) && (i_q == n_last) && (k_q == n_last);

  // Pick the neighbor read in this phase: k-, i-, j-, j+, i+, k+
  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = c_q;
    case (ph_q)
      3'd0: begin
        nb_ok   = (k_q != '0);
        nb_addr = c_q - plane_a;
      end
      3'd1: begin
        nb_ok   = (i_q != '0);
        nb_addr = c_q - n_a;
      end
      3'd2: begin
        nb_ok   = (j_q != '0);
        nb_addr = c_q - ADDR_W'(1);
      end
      3'd3: begin
        nb_ok   = (j_q != n_last);
        nb_addr = c_q + ADDR_W'(1);
      end
      3'd4: begin
        nb_ok   = (i_q != n_last);
        nb_addr = c_q + n_a;
      end
      3'd5: begin
        nb_ok   = (k_q != n_last);
        nb_addr = c_q + plane_a;
      end
      default: begin
        nb_ok   = 1'b0;
        nb_addr = c_q;
      end
    endcase
    if (!nb_ok) begin
      nb_addr = c_q;
    end
  end

  // Diagonal: six plus one per touched face
  always_comb begin
    diag = pgs_pkg::DIAG_BASE
         + pgs_pkg::DIAG_W'(j_q == '0) + pgs_pkg::DIAG_W'(j_q == n_last)
         + pgs_pkg::DIAG_W'(i_q == '0) + pgs_pkg::DIAG_W'(i_q == n_last)
         + pgs_pkg::DIAG_W'(k_q == '0) + pgs_pkg::DIAG_W'(k_q == n_last);
  end

  // Shared saturating adder operands
  assign add_a = (ph_q == 3'd1) ? src_rdata : acc_q;
  assign add_b = nb_ok_q ? sol_rdata : '0;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    done_d    = 1'b0;
    c_d       = c_q;
    j_d       = j_q;
    i_d       = i_q;
    k_d       = k_q;
    acc_d     = acc_q;
    nb_ok_d   = nb_ok_q;
    rd_d      = rd_q;
    stat_d    = stat_q;
    src_we    = 1'b0;
    sol_we    = 1'b0;
    wr_addr   = ADDR_W'(req_i.cell_index);
    sol_wdata = '0;
    rd_addr   = ADDR_W'(req_i.cell_index);
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_d   = 1'b0;
          stat_d = pgs_pkg::STATUS_OK;
          if (req_i.func == pgs_pkg::FUNC_SWEEP) begin
            state_d = ST_GATHER;
            ph_d    = '0;
            c_d     = '0;
            j_d     = '0;
            i_d     = '0;
            k_d     = '0;
          end else if (req_i.func == pgs_pkg::FUNC_LOAD ||
                       req_i.func == pgs_pkg::FUNC_READ) begin
            done_d = 1'b1;
            if (!in_grid) begin
              stat_d = pgs_pkg::STATUS_OUTSIDE;
            end else if (req_i.func == pgs_pkg::FUNC_LOAD) begin
              src_we = 1'b1;
              sol_we = 1'b1;
            end else begin
              rd_d = 1'b1;
            end
          end else begin
            done_d = 1'b1;
          end
        end
      end

      ST_GATHER: begin
        rd_addr = nb_addr;
        // issue one neighbor read per phase
        if (ph_q <= PH_LAST_READ) begin
          nb_ok_d = nb_ok;
        end
        // fold in the data read last phase
        if (ph_q != 3'd0 && ph_q <= PH_LAST_ADD) begin
          acc_d = pgs_pkg::sat_add(add_a, add_b);
        end
        if (ph_q == PH_DIV_GO) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          ph_d = ph_q + 3'd1;
        end
      end

      ST_DIV: begin
        wr_addr   = c_q;
        sol_wdata = div_quo;
        if (div_done) begin
          sol_we = 1'b1;
          ph_d   = '0;
          if (last_cell) begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = ST_GATHER;
            c_d     = c_q + ADDR_W'(1);
            // advance j, then i, then k
            if (j_q == n_last) begin
              j_d = '0;
              if (i_q == n_last) begin
                i_d = '0;
                k_d = k_q + N_W'(1);
              end else begin
                i_d = i_q + N_W'(1);
              end
            end else begin
              j_d = j_q + N_W'(1);
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= '0;
      done_q  <= 1'b0;
      n_q     <= N_W'(RST_N);
      plane_q <= PL_W'(RST_PL);
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        n_q     <= n_d;
        plane_q <= plane_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    j_q     <= j_d;
    i_q     <= i_d;
    k_q     <= k_d;
    acc_q   <= acc_d;
    nb_ok_q <= nb_ok_d;
    rd_q    <= rd_d;
    stat_q  <= stat_d;
  end

  pgs_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i       (clk_i),
    .src_we_i    (src_we),
    .sol_we_i    (sol_we),
    .wr_addr_i   (wr_addr),
    .src_wdata_i (req_i.source_value),
    .sol_wdata_i (sol_wdata),
    .src_raddr_i (busy ? c_q : rd_addr),
    .sol_raddr_i (rd_addr),
    .src_rdata_o (src_rdata),
    .sol_rdata_o (sol_rdata)
  );

  pgs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (diag),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Drive the result transaction
  assign done_o               = done_q;
  assign rsp_o.solution_value = rd_q ? sol_rdata : '0;
  assign rsp_o.status         = stat_q;

endmodule

`default_nettype wire
